// ===== rtl/mqtt_receive_packet_parser_defines.svh =====
// Assertion macros for the MQTT receive parser.
`ifndef MQTT_RECEIVE_PACKET_PARSER_DEFINES_SVH
`define MQTT_RECEIVE_PACKET_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on the rising clock edge, idle while reset is asserted.
`define MRPP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check a property on the rising clock edge, also during reset.
`define MRPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MRPP_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRPP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/mrpp_pkg.sv =====
package mrpp_pkg;

  localparam int unsigned MAX_LENGTH_BYTES = 4;

  localparam logic [7:0] LEN_CONT_BIT = 8'h80;
  localparam logic [6:0] LEN_DIGIT_MASK = 7'd127;

  // configuration register indexes
  localparam logic CFG_EXPECT_TYPE = 1'b0;
  localparam logic CFG_EXPECT_ID   = 1'b1;

  // control packet types
  localparam logic [3:0] PT_NONE     = 4'd0;
  localparam logic [3:0] PT_CONNACK  = 4'd2;
  localparam logic [3:0] PT_PUBLISH  = 4'd3;
  localparam logic [3:0] PT_PUBACK   = 4'd4;
  localparam logic [3:0] PT_PUBREL   = 4'd6;
  localparam logic [3:0] PT_UNSUBACK = 4'd11;

  localparam logic [1:0] QOS_0 = 2'd0;
  localparam logic [1:0] QOS_1 = 2'd1;
  localparam logic [1:0] QOS_2 = 2'd2;

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_LEN   = 3'd1,
    PH_TLEN  = 3'd2,
    PH_TOPIC = 3'd3,
    PH_ID    = 3'd4,
    PH_PAY   = 3'd5,
    PH_OTHER = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_HEADER    = 3'd0,
    ROLE_LENGTH    = 3'd1,
    ROLE_TOPIC_LEN = 3'd2,
    ROLE_TOPIC     = 3'd3,
    ROLE_PACKET_ID = 3'd4,
    ROLE_PAYLOAD   = 3'd5,
    ROLE_OTHER     = 3'd6,
    ROLE_LEN_ERR   = 3'd7
  } role_e;

  typedef enum logic [1:0] {
    REPLY_NONE    = 2'd0,
    REPLY_PUBACK  = 2'd1,
    REPLY_PUBREC  = 2'd2,
    REPLY_PUBCOMP = 2'd3
  } reply_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  header;
    logic [2:0]  len_cnt;
    logic [27:0] len_acc;
    logic [27:0] bytes_left;
    logic [15:0] topic_len;
    logic [15:0] topic_left;
    logic [15:0] id;
    logic        id_idx;
    logic [7:0]  code;
    logic [1:0]  body_cnt;   // body bytes seen, saturating
    logic [15:0] pend_id;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  data_byte;
    logic        end_of_packet;
    logic [3:0]  packet_type;
    logic [1:0]  qos;
    logic [15:0] packet_id;
    logic [27:0] remaining_length;
    logic [15:0] topic_length;
    logic        ack_match;
    logic [1:0]  reply_kind;
    logic        deliver;
    logic [7:0]  connack_code;
  } result_t;

endpackage

// ===== rtl/mrpp_if.sv =====
interface mrpp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrpp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  role;
  logic [7:0]  data_byte;
  logic        end_of_packet;
  logic [3:0]  packet_type;
  logic [1:0]  qos;
  logic [15:0] packet_id;
  logic [27:0] remaining_length;
  logic [15:0] topic_length;
  logic        ack_match;
  logic [1:0]  reply_kind;
  logic        deliver;
  logic [7:0]  connack_code;

  modport source (
    output valid, output role, output data_byte, output end_of_packet,
    output packet_type, output qos, output packet_id, output remaining_length,
    output topic_length, output ack_match, output reply_kind, output deliver,
    output connack_code, input ready
  );
  modport sink (
    input valid, input role, input data_byte, input end_of_packet,
    input packet_type, input qos, input packet_id, input remaining_length,
    input topic_length, input ack_match, input reply_kind, input deliver,
    input connack_code, output ready
  );
endinterface

// ===== rtl/mqtt_receive_packet_parser.sv =====
// MQTT 3.1.1 receive parser: takes one received byte per cycle on rx_i and returns one
// tagged result per byte on res_o, in the cycle after the byte is accepted. Each byte is
// decoded combinationally against the registered parse state and the result is held
// in an output register, so a byte is accepted every cycle while res_o is taken (or the
// output register is empty); the per-byte parse state update sets that rate.
// The result carries the byte's role, the decoded fixed header, remaining length, topic
// length and packet id, and on the last byte of a packet the acknowledgement match, the
// reply due and the delivery decision for a PUBLISH. Write expect_type (index 0) and
// expect_id (index 1) only while the parser is idle; expect_type clears itself on a match.
`include "mqtt_receive_packet_parser_defines.svh"

module mqtt_receive_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  mrpp_rx_if.sink     rx_i,
  mrpp_res_if.source  res_o
);

  mrpp_pkg::parse_state_t state_q, state_d;
  mrpp_pkg::result_t      res_q, res_d;
  logic                   res_valid_q;
  logic [3:0]             expect_type_q;
  logic [15:0]            expect_id_q;
  logic                   ack;
  logic                   rx_acc;

  mrpp_step u_step (
    .st_i          (state_q),
    .rx_byte_i     (rx_i.rx_byte),
    .expect_type_i (expect_type_q),
    .expect_id_i   (expect_id_q),
    .st_o          (state_d),
    .res_o         (res_d),
    .ack_o         (ack)
  );

  // take a new request while the output register is empty or draining
  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign rx_acc     = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (rx_acc) begin
        state_q <= state_d;
      end
      if (rx_acc) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_acc) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_type_q <= 4'd0;
      expect_id_q   <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mrpp_pkg::CFG_EXPECT_TYPE) begin
          expect_type_q <= cfg_wdata_i[3:0];
        end else if (cfg_idx_i == mrpp_pkg::CFG_EXPECT_ID) begin
          expect_id_q <= cfg_wdata_i;
        end
      end else if (rx_acc && ack) begin
        expect_type_q <= mrpp_pkg::PT_NONE;
      end
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.role             = res_q.role;
  assign res_o.data_byte        = res_q.data_byte;
  assign res_o.end_of_packet    = res_q.end_of_packet;
  assign res_o.packet_type      = res_q.packet_type;
  assign res_o.qos              = res_q.qos;
  assign res_o.packet_id        = res_q.packet_id;
  assign res_o.remaining_length = res_q.remaining_length;
  assign res_o.topic_length     = res_q.topic_length;
  assign res_o.ack_match        = res_q.ack_match;
  assign res_o.reply_kind       = res_q.reply_kind;
  assign res_o.deliver          = res_q.deliver;
  assign res_o.connack_code     = res_q.connack_code;

  `MRPP_ASSERT(a_eop_resync, clk_i, rst_ni,
    rx_acc && res_d.end_of_packet |=> state_q.phase == mrpp_pkg::PH_HDR,
    "parser not back at header after end of packet")
  `MRPP_ASSERT(a_len_err_resync, clk_i, rst_ni,
    rx_acc && res_d.role == mrpp_pkg::ROLE_LEN_ERR |=> state_q.phase == mrpp_pkg::PH_HDR,
    "parser not back at header after length error")
  `MRPP_ASSERT(a_ack_clears, clk_i, rst_ni,
    rx_acc && ack && !cfg_we_i |=> expect_type_q == mrpp_pkg::PT_NONE,
    "awaited type not cleared on match")
  `MRPP_ASSERT(a_reply_on_eop, clk_i, rst_ni,
    res_valid_q && (res_q.reply_kind != mrpp_pkg::REPLY_NONE || res_q.ack_match ||
                    res_q.deliver) |-> res_q.end_of_packet,
    "end-of-packet result outside the last byte")

endmodule

// ===== rtl/mrpp_step.sv =====
module mrpp_step (
  input  mrpp_pkg::parse_state_t st_i,
  input  logic [7:0]             rx_byte_i,
  input  logic [3:0]             expect_type_i,
  input  logic [15:0]            expect_id_i,
  output mrpp_pkg::parse_state_t st_o,
  output mrpp_pkg::result_t      res_o,
  output logic                   ack_o
);

  function automatic mrpp_pkg::phase_e first_body(input logic [3:0] ptype);
    mrpp_pkg::phase_e ph;
    if (ptype == mrpp_pkg::PT_PUBLISH) begin
      ph = mrpp_pkg::PH_TLEN;
    end else if (ptype >= mrpp_pkg::PT_PUBACK && ptype <= mrpp_pkg::PT_UNSUBACK) begin
      ph = mrpp_pkg::PH_ID;
    end else begin
      ph = mrpp_pkg::PH_OTHER;
    end
    return ph;
  endfunction

  function automatic mrpp_pkg::phase_e after_topic(input logic [1:0] q);
    return (q != mrpp_pkg::QOS_0) ? mrpp_pkg::PH_ID : mrpp_pkg::PH_PAY;
  endfunction

  mrpp_pkg::parse_state_t s;
  mrpp_pkg::role_e        role;
  mrpp_pkg::reply_e       reply;
  mrpp_pkg::phase_e       nxt;
  logic                   eop;
  logic                   ack;
  logic                   deliver;
  logic [27:0]            digit;
  logic [15:0]            tlen;
  logic [3:0]             ptype;
  logic [1:0]             qos;

  always_comb begin
    s       = st_i;
    role    = mrpp_pkg::ROLE_HEADER;
    reply   = mrpp_pkg::REPLY_NONE;
    nxt     = st_i.phase;
    eop     = 1'b0;
    ack     = 1'b0;
    deliver = 1'b0;
    digit   = '0;
    tlen    = '0;

    case (st_i.phase)
      mrpp_pkg::PH_HDR: begin
        s            = '0;
        s.pend_id    = st_i.pend_id;
        s.header     = rx_byte_i;
        s.phase      = mrpp_pkg::PH_LEN;
      end
      mrpp_pkg::PH_LEN: begin
        if (st_i.len_cnt >= 3'(mrpp_pkg::MAX_LENGTH_BYTES)) begin
          // too many length bytes: drop and resync on the next header
          role    = mrpp_pkg::ROLE_LEN_ERR;
          s.phase = mrpp_pkg::PH_HDR;
        end else begin
          role = mrpp_pkg::ROLE_LENGTH;
          if (st_i.len_cnt == 3'd2) begin
            s.code = rx_byte_i;
          end
          case (st_i.len_cnt[1:0])
            2'd0:    digit = {21'd0, rx_byte_i[6:0] & mrpp_pkg::LEN_DIGIT_MASK};
            2'd1:    digit = {14'd0, rx_byte_i[6:0] & mrpp_pkg::LEN_DIGIT_MASK, 7'd0};
            2'd2:    digit = {7'd0, rx_byte_i[6:0] & mrpp_pkg::LEN_DIGIT_MASK, 14'd0};
            default: digit = {rx_byte_i[6:0] & mrpp_pkg::LEN_DIGIT_MASK, 21'd0};
          endcase
          s.len_acc = st_i.len_acc | digit;
          s.len_cnt = st_i.len_cnt + 3'd1;
          if ((rx_byte_i & mrpp_pkg::LEN_CONT_BIT) == 8'd0) begin
            s.bytes_left = s.len_acc;
            if (s.len_acc == 28'd0) begin
              eop     = 1'b1;
              s.phase = mrpp_pkg::PH_HDR;
            end else begin
              s.id_idx = 1'b0;
              s.phase  = first_body(st_i.header[7:4]);
            end
          end
        end
      end
      default: begin
        // packet offset 3 holds the CONNACK return code
        if ((4'(st_i.len_cnt) + 4'(st_i.body_cnt)) == 4'd2) begin
          s.code = rx_byte_i;
        end
        if (st_i.body_cnt != 2'd3) begin
          s.body_cnt = st_i.body_cnt + 2'd1;
        end
        case (st_i.phase)
          mrpp_pkg::PH_TLEN: begin
            role        = mrpp_pkg::ROLE_TOPIC_LEN;
            tlen        = {st_i.topic_len[7:0], rx_byte_i};
            s.topic_len = tlen;
            if (!st_i.id_idx) begin
              s.id_idx = 1'b1;
            end else begin
              s.id_idx     = 1'b0;
              s.topic_left = tlen;
              nxt = (tlen != 16'd0) ? mrpp_pkg::PH_TOPIC : after_topic(st_i.header[2:1]);
            end
          end
          mrpp_pkg::PH_TOPIC: begin
            role         = mrpp_pkg::ROLE_TOPIC;
            s.topic_left = st_i.topic_left - 16'd1;
            if (s.topic_left == 16'd0) begin
              nxt = after_topic(st_i.header[2:1]);
            end
          end
          mrpp_pkg::PH_ID: begin
            role = mrpp_pkg::ROLE_PACKET_ID;
            s.id = {st_i.id[7:0], rx_byte_i};
            if (!st_i.id_idx) begin
              s.id_idx = 1'b1;
            end else begin
              s.id_idx = 1'b0;
              nxt = (st_i.header[7:4] == mrpp_pkg::PT_PUBLISH) ? mrpp_pkg::PH_PAY
                                                               : mrpp_pkg::PH_OTHER;
            end
          end
          mrpp_pkg::PH_PAY: begin
            role = mrpp_pkg::ROLE_PAYLOAD;
          end
          default: begin
            role = mrpp_pkg::ROLE_OTHER;
          end
        endcase
        s.bytes_left = st_i.bytes_left - 28'd1;
        if (s.bytes_left == 28'd0) begin
          eop     = 1'b1;
          s.phase = mrpp_pkg::PH_HDR;
        end else begin
          s.phase = nxt;
        end
      end
    endcase

    ptype = s.header[7:4];
    qos   = s.header[2:1];

    if (eop) begin
      if ((expect_type_i != mrpp_pkg::PT_NONE && expect_type_i == ptype &&
           expect_id_i == s.id) || expect_type_i == mrpp_pkg::PT_CONNACK) begin
        ack = 1'b1;
      end
      if (ptype == mrpp_pkg::PT_PUBLISH) begin
        deliver = 1'b1;
        if (qos == mrpp_pkg::QOS_1) begin
          reply = mrpp_pkg::REPLY_PUBACK;
        end else if (qos == mrpp_pkg::QOS_2) begin
          // drop a QoS-2 redelivery of the id already pending
          if (st_i.pend_id != 16'd0 && st_i.pend_id == s.id) begin
            deliver = 1'b0;
          end
          s.pend_id = s.id;
          reply     = mrpp_pkg::REPLY_PUBREC;
        end
      end else if (ptype == mrpp_pkg::PT_PUBREL) begin
        s.pend_id = 16'd0;
        reply     = mrpp_pkg::REPLY_PUBCOMP;
      end
    end
  end

  assign st_o  = s;
  assign ack_o = ack;

  assign res_o.role             = role;
  assign res_o.data_byte        = rx_byte_i;
  assign res_o.end_of_packet    = eop;
  assign res_o.packet_type      = ptype;
  assign res_o.qos              = qos;
  assign res_o.packet_id        = s.id;
  assign res_o.remaining_length = s.len_acc;
  assign res_o.topic_length     = s.topic_len;
  assign res_o.ack_match        = ack;
  assign res_o.reply_kind       = reply;
  assign res_o.deliver          = deliver;
  assign res_o.connack_code     = s.code;

endmodule
